// ===== src/dvr_pkg.sv =====
// shared types and constants of the distance vector route engine
package dvr_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = 4;
  localparam int COST_W    = 5;
  localparam int HOP_W     = 5;
  localparam int TTL_W     = 24;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int EDGES     = MAX_NODES * MAX_NODES;

  localparam logic [COST_W-1:0] COST_INF = 5'd16;
  localparam logic [HOP_W-1:0]  NO_HOP   = 5'd16;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_EDGE = 3'd1;
  localparam logic [2:0] OP_RELAX = 3'd2;
  localparam logic [2:0] OP_AGE = 3'd3;
  localparam logic [2:0] OP_PRUNE = 3'd4;
  localparam logic [2:0] OP_NUP = 3'd5;
  localparam logic [2:0] OP_READ = 3'd6;
  localparam logic [2:0] OP_READ_ALT = 3'd7;

  localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_PERIOD      = 2'd1;
  localparam logic [1:0] CFG_TTL_PERIODS = 2'd2;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [NODE_W-1:0] row_index;
    logic [NODE_W-1:0] col_index;
    logic [COST_W-1:0] edge_cost;
  } in_t;

  typedef struct packed {
    logic [COST_W-1:0] dist_cost;
    logic [HOP_W-1:0]  hop_node;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [COST_W-1:0] wcost;
    logic [TTL_W-1:0]  wttl;
    logic [ADDR_W-1:0] raddr;
  } edge_req_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [TTL_W-1:0]  ttl;
  } edge_t;

endpackage

// ===== src/distance_vector_route_engine.sv =====
// top level: control sequencer, distance vector and configuration registers
// Usage of the route engine.
// Requests enter on in_valid/in_stall with an in_t payload; each request returns one
// out_t on out_valid/out_stall: the vector entry at row_index after the operation.
// Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data: index 0 node_count, 1 period, 2 ttl_periods; other indexes are ignored.
// One request is handled at a time; in_stall is high from acceptance until the result
// has been loaded into the output register.
// Init, set edge, prune and read go from the execute state to the done state;
// neighbour up also passes through a state that writes its edge from node 0.
// Relax and age walk the n by n edge matrix, n = min(node_count, 16), reading one edge
// per cycle from the edge ram, whose read is registered; age then also passes through
// a state for restoring the self edge.
// Reset is synchronous: the edge matrix reads as infinite cost and zero ttl through
// per entry valid bits, so no clearing pass is needed; the vector is all infinite with
// no next hop and configuration returns to 16, 1 and 6.
// While the receiver stalls, the finished result waits in the sequencer and no new
// request is accepted; a result already in the output register is held unchanged.
module distance_vector_route_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dvr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dvr_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import dvr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_PASS   = 3'd2;
  localparam logic [2:0] ST_AGEFIX = 3'd3;
  localparam logic [2:0] ST_NUP2   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]  state;
  logic [4:0]  node_count;
  logic [15:0] period;
  logic [7:0]  ttl_periods;

  in_t               req;
  logic [COST_W-1:0] req_cost;
  logic [COST_W-1:0] dist_cost [MAX_NODES];
  logic [HOP_W-1:0]  hop_reg [MAX_NODES];

  logic [NODE_W-1:0] ri, rj, s2_i, s2_j;
  logic              issue, s2_valid;

  edge_req_t         ereq;
  edge_t             erd;
  logic [TTL_W-1:0]  full_ttl;
  logic [4:0]        n, nm1;
  logic              last_j, last_i;
  logic [COST_W:0]   sum_w;
  logic [COST_W-1:0] sum;
  logic [TTL_W-1:0]  ttl_dec;
  logic              take_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign full_ttl  = {16'b0, ttl_periods} * {8'b0, period};
  assign n         = (node_count > 5'd16) ? 5'd16 : node_count;
  assign nm1       = n - 5'd1;
  assign last_j    = ({1'b0, rj} == nm1);
  assign last_i    = ({1'b0, ri} == nm1);
  assign req_cost  = (req.edge_cost > COST_INF) ? COST_INF : req.edge_cost;
  assign sum_w     = {1'b0, dist_cost[s2_i]} + {1'b0, erd.cost};
  assign sum       = (sum_w > {1'b0, COST_INF}) ? COST_INF : sum_w[COST_W-1:0];
  assign ttl_dec   = (erd.ttl > {8'b0, period}) ? erd.ttl - {8'b0, period} : '0;
  assign take_out  = !out_valid || !out_stall;

  dvr_edge_mem u_edges (
    .clk (clk),
    .rst (rst),
    .req (ereq),
    .rd  (erd)
  );

  always_comb begin
    ereq.we    = 1'b0;
    ereq.waddr = '0;
    ereq.wcost = '0;
    ereq.wttl  = full_ttl;
    ereq.raddr = {ri, rj};
    unique case (state)
      ST_EXEC: begin
        if (req.opcode == OP_EDGE) begin
          ereq.we    = 1'b1;
          ereq.waddr = {req.row_index, req.col_index};
          ereq.wcost = req_cost;
        end else if (req.opcode == OP_NUP) begin
          ereq.we    = 1'b1;
          ereq.waddr = {req.row_index, req.row_index};
          ereq.wcost = '0;
        end
      end
      ST_NUP2: begin
        ereq.we    = 1'b1;
        ereq.waddr = {{NODE_W{1'b0}}, req.row_index};
        ereq.wcost = 5'd1;
      end
      ST_AGEFIX: begin
        ereq.we    = 1'b1;
        ereq.waddr = '0;
        ereq.wcost = '0;
      end
      ST_PASS: begin
        if (s2_valid && req.opcode == OP_AGE && erd.cost != COST_INF) begin
          ereq.we    = 1'b1;
          ereq.waddr = {s2_i, s2_j};
          ereq.wcost = (ttl_dec == '0) ? COST_INF : erd.cost;
          ereq.wttl  = ttl_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= 5'd16;
      period      <= 16'd1;
      ttl_periods <= 8'd6;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NODE_COUNT:  node_count  <= cfg_data[4:0];
        CFG_PERIOD:      period      <= cfg_data;
        CFG_TTL_PERIODS: ttl_periods <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      issue     <= 1'b0;
      s2_valid  <= 1'b0;
      ri        <= '0;
      rj        <= '0;
      for (int e = 0; e < MAX_NODES; e++) begin
        dist_cost[e] <= COST_INF;
        hop_reg[e]   <= NO_HOP;
      end
    end else begin
      if (state == ST_DONE && take_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_DONE;
          unique case (req.opcode)
            OP_INIT: begin
              for (int e = 0; e < MAX_NODES; e++) begin
                if (e == 0) begin
                  dist_cost[e] <= '0;
                  hop_reg[e]   <= '0;
                end else if (5'(e) < n) begin
                  dist_cost[e] <= COST_INF;
                  hop_reg[e]   <= NO_HOP;
                end
              end
            end
            OP_RELAX, OP_AGE: begin
              ri <= '0;
              rj <= '0;
              if (n != 5'd0) begin
                issue <= 1'b1;
                state <= ST_PASS;
              end else if (req.opcode == OP_AGE) begin
                state <= ST_AGEFIX;
              end
            end
            OP_PRUNE: begin
              for (int e = 0; e < MAX_NODES; e++) begin
                if (5'(e) < n && hop_reg[e] != NO_HOP && hop_reg[e] != '0 &&
                    dist_cost[e] > 5'd1) begin
                  dist_cost[e] <= COST_INF;
                end
              end
            end
            OP_NUP: begin
              dist_cost[req.row_index] <= 5'd1;
              hop_reg[req.row_index]   <= {1'b0, req.row_index};
              state                    <= ST_NUP2;
            end
            default: ;
          endcase
        end
        ST_PASS: begin
          s2_valid <= issue;
          s2_i     <= ri;
          s2_j     <= rj;
          if (issue) begin
            if (last_j) begin
              rj <= '0;
              ri <= ri + 1'b1;
              if (last_i) begin
                issue <= 1'b0;
              end
            end else begin
              rj <= rj + 1'b1;
            end
          end
          if (s2_valid) begin
            if (req.opcode == OP_RELAX) begin
              if (dist_cost[s2_j] > sum) begin
                dist_cost[s2_j] <= sum;
                hop_reg[s2_j]   <= {1'b0, s2_i};
              end
            end else if (erd.cost != COST_INF && ttl_dec == '0) begin
              dist_cost[s2_j] <= COST_INF;
            end
          end
          if (!issue && !s2_valid) begin
            state <= (req.opcode == OP_AGE) ? ST_AGEFIX : ST_DONE;
          end
        end
        ST_AGEFIX: begin
          dist_cost[0] <= '0;
          state        <= ST_DONE;
        end
        ST_NUP2: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (take_out) begin
            out_data.dist_cost <= dist_cost[req.row_index];
            out_data.hop_node  <= hop_reg[req.row_index];
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_EXEC)
    else $error("accepted request did not start execution");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ereq.we)
    else $error("edge write while idle");

  a_s2_in_pass: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> state == ST_PASS)
    else $error("pass stage active outside a pass");

  a_self_restored: assert property (@(posedge clk) disable iff (rst)
    state == ST_AGEFIX |=> dist_cost[0] == '0)
    else $error("self distance not restored after age");

endmodule

// ===== src/dvr_ram.sv =====
// generic single port write, registered read ram
module dvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dvr_edge_mem.sv =====
// edge cost and ttl store with per entry valid bits giving the reset value
module dvr_edge_mem (
  input  logic              clk,
  input  logic              rst,
  input  dvr_pkg::edge_req_t req,
  output dvr_pkg::edge_t    rd
);
  import dvr_pkg::*;

  logic [EDGES-1:0] valid;
  logic             rvalid;
  edge_t            ram_rd;
  edge_t            wdata;

  assign wdata.cost = req.wcost;
  assign wdata.ttl  = req.wttl;

  dvr_ram #(.WIDTH(COST_W + TTL_W), .DEPTH(EDGES)) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (wdata),
    .raddr (req.raddr),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= valid[req.raddr];
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (rvalid) begin
      rd = ram_rd;
    end else begin
      rd.cost = COST_INF;
      rd.ttl  = '0;
    end
  end

endmodule

// ===== sim/dvr_checker.sv =====
// checker: watches the request and result channels, predicts route entries and compares
module dvr_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  dvr_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  dvr_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output int            fail_count,
  output int            pending_count
);
  import dvr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [COST_W-1:0] link_cost [EDGES];
  logic [TTL_W-1:0]  link_ttl [EDGES];
  logic [COST_W-1:0] route_cost [MAX_NODES];
  logic [HOP_W-1:0]  route_hop [MAX_NODES];
  logic [4:0]        nodes_cfg;
  logic [15:0]       period_cfg;
  logic [7:0]        ttl_cfg;
  out_t              route_queue [$];

  assign pending_count = route_queue.size();

  function automatic logic [TTL_W-1:0] fresh_ttl();
    logic [31:0] p;
    p = ttl_cfg * period_cfg;
    return p[TTL_W-1:0];
  endfunction

  task automatic report(string what, logic [4:0] got, logic [4:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic predict_route(in_t req);
    int n, i, j, k;
    logic [5:0] sum;
    logic [4:0] c;
    logic [23:0] t;
    out_t res;
    n = nodes_cfg > MAX_NODES ? MAX_NODES : nodes_cfg;
    c = req.edge_cost > COST_INF ? COST_INF : req.edge_cost;
    case (req.opcode)
      OP_INIT: begin
        for (i = 0; i < n; i++) begin
          route_cost[i] = COST_INF;
          route_hop[i] = NO_HOP;
        end
        route_cost[0] = 0;
        route_hop[0] = 0;
      end
      OP_EDGE: begin
        k = req.row_index * MAX_NODES + req.col_index;
        link_cost[k] = c;
        link_ttl[k] = fresh_ttl();
      end
      OP_RELAX: begin
        for (i = 0; i < n; i++)
          for (j = 0; j < n; j++) begin
            sum = route_cost[i] + link_cost[i*MAX_NODES+j];
            if (sum > COST_INF) sum = COST_INF;
            if (route_cost[j] > sum) begin
              route_cost[j] = sum[4:0];
              route_hop[j] = i[4:0];
            end
          end
      end
      OP_AGE: begin
        for (i = 0; i < n; i++)
          for (j = 0; j < n; j++) begin
            k = i * MAX_NODES + j;
            if (link_cost[k] != COST_INF) begin
              t = link_ttl[k] > period_cfg ? link_ttl[k] - period_cfg : 0;
              link_ttl[k] = t;
              if (t == 0) begin
                link_cost[k] = COST_INF;
                route_cost[j] = COST_INF;
              end
            end
          end
        link_cost[0] = 0;
        link_ttl[0] = fresh_ttl();
        route_cost[0] = 0;
      end
      OP_PRUNE: begin
        for (i = 0; i < n; i++)
          if (route_hop[i] != NO_HOP && route_hop[i] != 0 && route_cost[i] > 1)
            route_cost[i] = COST_INF;
      end
      OP_NUP: begin
        i = req.row_index;
        link_cost[i*MAX_NODES+i] = 0;
        link_ttl[i*MAX_NODES+i] = fresh_ttl();
        link_cost[i] = 1;
        link_ttl[i] = fresh_ttl();
        route_cost[i] = 1;
        route_hop[i] = i[4:0];
      end
      default: ;
    endcase
    res.dist_cost = route_cost[req.row_index];
    res.hop_node = route_hop[req.row_index];
    route_queue.push_back(res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EDGES; i++) begin
        link_cost[i] = COST_INF;
        link_ttl[i] = 0;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
        route_cost[i] = COST_INF;
        route_hop[i] = NO_HOP;
      end
      nodes_cfg = 16;
      period_cfg = 1;
      ttl_cfg = 6;
      route_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODE_COUNT:  nodes_cfg = cfg_data[4:0];
          CFG_PERIOD:      period_cfg = cfg_data;
          CFG_TTL_PERIODS: ttl_cfg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_route(in_data);
      if (out_valid && !out_stall) begin
        if (route_queue.size() == 0) begin
          $display("unexpected result at %0t", $time);
          fail_count++;
        end else begin
          out_t want;
          want = route_queue.pop_front();
          if (out_data.dist_cost !== want.dist_cost)
            report("dist_cost", out_data.dist_cost, want.dist_cost);
          if (out_data.hop_node !== want.hop_node)
            report("hop_node", out_data.hop_node, want.hop_node);
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

// ===== sim/tb_distance_vector_route_engine.sv =====
// testbench top: request stimulus, configuration phases and verdict
module tb_distance_vector_route_engine;
  import dvr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_t in_data;
  out_t out_data;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count, pending_count;
  int send_idle_pct, recv_idle_pct, hold_cycles;

  distance_vector_route_engine dut (.*);
  dvr_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else
      out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_request(logic [2:0] op, logic [3:0] row, logic [3:0] col,
                              logic [4:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op, row, col, cost};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (270) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) < 7) begin
        // well-formed build: init, neighbours, edges, relax, age or prune, and reads
        case ($urandom_range(5))
          0: send_request(OP_INIT, $urandom, $urandom, $urandom);
          1: send_request(OP_NUP, $urandom, $urandom, $urandom);
          2: send_request(OP_EDGE, $urandom, $urandom, $urandom_range(16));
          3: send_request(OP_RELAX, $urandom, $urandom, $urandom);
          4: send_request($urandom_range(1) ? OP_AGE : OP_PRUNE, $urandom, $urandom,
                          $urandom);
          default: send_request($urandom_range(1) ? OP_READ_ALT : OP_READ, $urandom,
                                $urandom, $urandom);
        endcase
      end else
        send_request($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst = 1; in_valid = 0; in_data = '0; out_stall = 0; cfg_valid = 0;
    cfg_index = CFG_NODE_COUNT; cfg_data = '0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reads from reset, extremes, every opcode
    send_request(OP_READ, 4'd15, 4'd0, 5'd0);
    send_request(OP_READ_ALT, 4'd0, 4'd15, 5'd31);
    send_request(OP_INIT, 4'd0, 4'd0, 5'd0);
    send_request(OP_NUP, 4'd0, 4'd0, 5'd0);
    send_request(OP_NUP, 4'd15, 4'd0, 5'd0);
    send_request(OP_NUP, 4'd3, 4'd0, 5'd0);
    send_request(OP_EDGE, 4'd15, 4'd15, 5'd31);
    send_request(OP_EDGE, 4'd3, 4'd7, 5'd0);
    send_request(OP_EDGE, 4'd15, 4'd9, 5'd16);
    send_request(OP_EDGE, 4'd3, 4'd9, 5'd15);
    send_request(OP_RELAX, 4'd7, 4'd0, 5'd0);
    send_request(OP_RELAX, 4'd9, 4'd0, 5'd0);
    send_request(OP_PRUNE, 4'd7, 4'd0, 5'd0);
    send_request(OP_PRUNE, 4'd9, 4'd0, 5'd0);
    repeat (7) send_request(OP_AGE, 4'd3, 4'd0, 5'd0);
    send_request(OP_AGE, 4'd0, 4'd0, 5'd0);
    drain();
    // phase 1: small nodes, long then short ttl
    write_reg(CFG_NODE_COUNT, 16'd1);
    write_reg(CFG_PERIOD, 16'd65535);
    write_reg(CFG_TTL_PERIODS, 16'd255);
    send_idle_pct = 17; recv_idle_pct = 79;
    random_phase(60);
    drain();
    write_reg(CFG_NODE_COUNT, 16'd4);
    write_reg(CFG_PERIOD, 16'd1);
    write_reg(CFG_TTL_PERIODS, 16'd1);
    random_phase(140);
    drain();
    // phase 2: swap idling, long receiver hold-off
    write_reg(CFG_NODE_COUNT, 16'd6);
    write_reg(CFG_PERIOD, 16'd3);
    write_reg(CFG_TTL_PERIODS, 16'd5);
    send_idle_pct = 79; recv_idle_pct = 17;
    hold_cycles = 400;
    random_phase(150);
    drain();
    // phase 3: no idling, full node count, odd value above range
    write_reg(CFG_NODE_COUNT, 16'd31);
    write_reg(CFG_PERIOD, 16'd2);
    write_reg(CFG_TTL_PERIODS, 16'd4);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(80);
    drain();
    write_reg(CFG_NODE_COUNT, 16'd16);
    write_reg(CFG_NODE_COUNT, 16'd5);
    random_phase(170);
    drain();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

// ===== files.f =====
src/dvr_pkg.sv
src/dvr_ram.sv
src/dvr_edge_mem.sv
src/distance_vector_route_engine.sv
sim/dvr_checker.sv
sim/tb_distance_vector_route_engine.sv
